FILE: hdl/tsms_pkg.sv
`timescale 1ns / 1ps
package tsms_pkg;

	// Text window and counters
	localparam int WINDOW_LEN = 10;
	localparam int COUNT_SAT  = 16;
	localparam int COUNT_W    = 5;
	localparam int HOUR_W     = 64;
	localparam int REST_W     = 22;
	localparam int PROD_W     = 54;

	typedef logic [7:0]              char_t;
	typedef char_t [WINDOW_LEN-1:0]  window_t;
	typedef logic [COUNT_W-1:0]      count_t;
	typedef logic [HOUR_W-1:0]       hour_t;
	typedef logic [REST_W-1:0]       rest_t;
	typedef logic [PROD_W-1:0]       prod_t;
	typedef logic [3:0]              digit_t;

	// Character codes
	localparam char_t CHAR_ZERO  = 8'h30;
	localparam char_t CHAR_NINE  = 8'h39;
	localparam char_t CHAR_COLON = 8'h3A;
	localparam char_t CHAR_DOT   = 8'h2E;

	// Lengths that the format allows, the window length and the count's saturation value
	localparam count_t LEN_SHORT    = count_t'(9);
	localparam count_t LEN_HOURS    = count_t'(12);
	localparam count_t LEN_WINDOW   = count_t'(WINDOW_LEN);
	localparam count_t LEN_SAT      = count_t'(COUNT_SAT);

	// Range limits and scale factors
	localparam digit_t MAX_TENS_DIGIT = 4'd5;
	localparam logic [21:0] MS_PER_HOUR   = 22'd3600000;
	localparam logic [15:0] MS_PER_MINUTE = 16'd60000;
	localparam logic [9:0]  MS_PER_SECOND = 10'd1000;

	// Collected text of one timestamp, handed to the checker
	typedef struct packed {
		window_t window;
		count_t  count;
		hour_t   hour_value;
		logic    hour_overflow;
		logic    hour_nondigit;
	} stamp_t;

	// Checked fields and partial hour products
	typedef struct packed {
		logic  form_ok;
		rest_t rest;
		prod_t prod_lo;
		prod_t prod_hi;
	} parts_t;

	function automatic logic is_digit(input char_t c);
		return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
	endfunction

	function automatic digit_t digit_of(input char_t c);
		char_t diff;
		diff = c - CHAR_ZERO;
		return diff[3:0];
	endfunction

endpackage

FILE: hdl/tsms_if.sv
`timescale 1ns / 1ps
// Character stream: one byte per beat, last marks the end of a timestamp
interface tsms_in_if;
	logic                  valid;
	logic                  ready;
	tsms_pkg::char_t       character;
	logic                  last;

	modport source (output valid, character, last, input ready);
	modport sink   (input valid, character, last, output ready);
endinterface

// Result stream: one beat per timestamp
interface tsms_out_if;
	logic        valid;
	logic        ready;
	logic [63:0] milliseconds;
	logic        valid_res;

	modport source (output valid, milliseconds, valid_res, input ready);
	modport sink   (input valid, milliseconds, valid_res, output ready);
endinterface

FILE: hdl/tsms_collect.sv
`timescale 1ns / 1ps
module tsms_collect (
	input  logic              clk,
	input  logic              arst_n,
	tsms_in_if.sink           text,
	output logic              stamp_valid,
	output tsms_pkg::stamp_t  stamp_s1,
	input  logic              stamp_ready
);

	tsms_pkg::window_t win_q;
	tsms_pkg::count_t  count_q;
	tsms_pkg::hour_t   hour_q;
	logic              ovf_q;
	logic              nondig_q;
	logic              valid_q;

	tsms_pkg::char_t   leaving;
	logic              take;
	logic              leave_digit;
	logic [67:0]       hour_wide;
	tsms_pkg::stamp_t  next;
	logic              adv;
	logic              accept;

	// Oldest character leaves the window and joins the hour digits
	always_comb begin
		leaving     = win_q[0];
		take        = count_q >= tsms_pkg::LEN_WINDOW;
		leave_digit = tsms_pkg::is_digit(leaving);
		hour_wide   = ({4'b0, hour_q} << 3) + ({4'b0, hour_q} << 1)
			+ {64'b0, tsms_pkg::digit_of(leaving)};

		next.window        = {text.character, win_q[tsms_pkg::WINDOW_LEN-1:1]};
		next.count         = (count_q < tsms_pkg::LEN_SAT) ? count_q + 1'b1 : count_q;
		next.hour_value    = hour_q;
		next.hour_overflow = ovf_q;
		next.hour_nondigit = nondig_q | (take & ~leave_digit);
		if (take && leave_digit && !ovf_q) begin
			if (hour_wide[67:64] != 4'b0) begin
				next.hour_overflow = 1'b1;
			end else begin
				next.hour_value = hour_wide[63:0];
			end
		end
	end

	assign adv        = ~valid_q | stamp_ready;
	assign text.ready = adv;
	assign accept     = text.valid & adv;

	// Accumulated state, cleared after each last beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q    <= '0;
			count_q  <= '0;
			hour_q   <= '0;
			ovf_q    <= 1'b0;
			nondig_q <= 1'b0;
		end else if (accept) begin
			if (text.last) begin
				win_q    <= '0;
				count_q  <= '0;
				hour_q   <= '0;
				ovf_q    <= 1'b0;
				nondig_q <= 1'b0;
			end else begin
				win_q    <= next.window;
				count_q  <= next.count;
				hour_q   <= next.hour_value;
				ovf_q    <= next.hour_overflow;
				nondig_q <= next.hour_nondigit;
			end
		end
	end

	// Stage 1 valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (adv) begin
			valid_q <= accept & text.last;
		end
	end

	// Stage 1 payload
	always_ff @(posedge clk) begin
		if (accept && text.last) begin
			stamp_s1 <= next;
		end
	end

	assign stamp_valid = valid_q;

endmodule

FILE: hdl/tsms_check.sv
`timescale 1ns / 1ps
module tsms_check (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              stamp_valid,
	input  tsms_pkg::stamp_t  stamp_s1,
	output logic              stamp_ready,
	output logic              parts_valid,
	output tsms_pkg::parts_t  parts_s2,
	input  logic              parts_ready
);

	logic              valid_q;
	logic              adv;
	tsms_pkg::window_t w;
	tsms_pkg::count_t  len;
	logic              hours_ok;
	logic              digits_ok;
	logic [6:0]        minutes;
	logic [6:0]        seconds;
	logic [9:0]        millis;
	tsms_pkg::parts_t  parts;

	// Layout, digit and range checks; minute/second/ms sum; hour products
	always_comb begin
		w   = stamp_s1.window;
		len = stamp_s1.count;

		hours_ok = (len == tsms_pkg::LEN_SHORT)
			|| ((len >= tsms_pkg::LEN_HOURS) && (w[0] == tsms_pkg::CHAR_COLON)
				&& !stamp_s1.hour_nondigit && !stamp_s1.hour_overflow);

		digits_ok = tsms_pkg::is_digit(w[1]) && tsms_pkg::is_digit(w[2])
			&& tsms_pkg::is_digit(w[4]) && tsms_pkg::is_digit(w[5])
			&& tsms_pkg::is_digit(w[7]) && tsms_pkg::is_digit(w[8])
			&& tsms_pkg::is_digit(w[9]);

		minutes = 7'(tsms_pkg::digit_of(w[1])) * 7'd10 + 7'(tsms_pkg::digit_of(w[2]));
		seconds = 7'(tsms_pkg::digit_of(w[4])) * 7'd10 + 7'(tsms_pkg::digit_of(w[5]));
		millis  = 10'(tsms_pkg::digit_of(w[7])) * 10'd100
			+ 10'(tsms_pkg::digit_of(w[8])) * 10'd10
			+ 10'(tsms_pkg::digit_of(w[9]));

		parts.form_ok = (len >= tsms_pkg::LEN_SHORT) && hours_ok
			&& (w[3] == tsms_pkg::CHAR_COLON) && (w[6] == tsms_pkg::CHAR_DOT)
			&& digits_ok
			&& (tsms_pkg::digit_of(w[1]) <= tsms_pkg::MAX_TENS_DIGIT)
			&& (tsms_pkg::digit_of(w[4]) <= tsms_pkg::MAX_TENS_DIGIT);

		parts.rest = tsms_pkg::rest_t'(minutes) * tsms_pkg::rest_t'(tsms_pkg::MS_PER_MINUTE)
			+ tsms_pkg::rest_t'(seconds) * tsms_pkg::rest_t'(tsms_pkg::MS_PER_SECOND)
			+ tsms_pkg::rest_t'(millis);

		// Hours times ms per hour, split into two 32-bit halves
		parts.prod_lo = tsms_pkg::prod_t'(stamp_s1.hour_value[31:0])
			* tsms_pkg::prod_t'(tsms_pkg::MS_PER_HOUR);
		parts.prod_hi = tsms_pkg::prod_t'(stamp_s1.hour_value[63:32])
			* tsms_pkg::prod_t'(tsms_pkg::MS_PER_HOUR);
	end

	assign adv         = ~valid_q | parts_ready;
	assign stamp_ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (adv) begin
			valid_q <= stamp_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && stamp_valid) begin
			parts_s2 <= parts;
		end
	end

	assign parts_valid = valid_q;

endmodule

FILE: hdl/tsms_total.sv
`timescale 1ns / 1ps
module tsms_total (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              parts_valid,
	input  tsms_pkg::parts_t  parts_s2,
	output logic              parts_ready,
	tsms_out_if.source        result
);

	logic        valid_q;
	logic [63:0] ms_q;
	logic        ok_q;
	logic        adv;
	logic [64:0] sum;
	logic        too_big;
	logic        ok;

	// Final total with a check for overflow past 64 bits
	always_comb begin
		sum = {1'b0, parts_s2.prod_hi[31:0], 32'b0}
			+ {11'b0, parts_s2.prod_lo}
			+ {43'b0, parts_s2.rest};
		too_big = sum[64] | (parts_s2.prod_hi[53:32] != 22'b0);
		ok      = parts_s2.form_ok & ~too_big;
	end

	assign adv         = ~valid_q | result.ready;
	assign parts_ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (adv) begin
			valid_q <= parts_valid;
		end
	end

	// Output register
	always_ff @(posedge clk) begin
		if (adv && parts_valid) begin
			ms_q <= ok ? sum[63:0] : 64'b0;
			ok_q <= ok;
		end
	end

	assign result.valid        = valid_q;
	assign result.milliseconds = ms_q;
	assign result.valid_res    = ok_q;

endmodule

FILE: hdl/timestamp_text_to_milliseconds.sv
`timescale 1ns / 1ps
// After the last character beat is accepted, the stamp, parts and result registers take it in turn.
// Throughput: one character beat per cycle unless stalled; a timestamp may start right after the last beat.
// Stages: character window and hour accumulator, field checks and hour products, final sum.
// Reset (arst_n, async, active low) clears the window, count, hour state and stage valids.
module timestamp_text_to_milliseconds (
	input  logic        clk,
	input  logic        arst_n,
	tsms_in_if.sink     text,
	tsms_out_if.source  result
);

	logic              stamp_valid;
	logic              stamp_ready;
	tsms_pkg::stamp_t  stamp_s1;
	logic              parts_valid;
	logic              parts_ready;
	tsms_pkg::parts_t  parts_s2;

	tsms_collect u_collect (
		.clk         (clk),
		.arst_n      (arst_n),
		.text        (text),
		.stamp_valid (stamp_valid),
		.stamp_s1    (stamp_s1),
		.stamp_ready (stamp_ready)
	);

	tsms_check u_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.stamp_valid (stamp_valid),
		.stamp_s1    (stamp_s1),
		.stamp_ready (stamp_ready),
		.parts_valid (parts_valid),
		.parts_s2    (parts_s2),
		.parts_ready (parts_ready)
	);

	tsms_total u_total (
		.clk         (clk),
		.arst_n      (arst_n),
		.parts_valid (parts_valid),
		.parts_s2    (parts_s2),
		.parts_ready (parts_ready),
		.result      (result)
	);

endmodule
